@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: lbl");

// Consequent must hold in the clock cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/bdeq_pkg.sv @@
package bdeq_pkg;

    // Ring depth and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Command codes; the two remaining codes are no-ops.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Request and result payloads.
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] data_in;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [4:0]         item_count;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

endpackage

@@ rtl/bdeq_ctrl.sv @@
`include "assert_macros.svh"

module bdeq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_done,
    output bdeq_pkg::t_dp_ctrl o_ctrl
);
    import bdeq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a request, execute it, then present the result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        busy        = 1'b1;
        o_done      = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                o_ctrl.load = start;
            end
            ST_EXEC: begin
                o_ctrl.exec = 1'b1;
            end
            ST_RESP: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `ASSERT_NEXT(a_exec_then_done, i_clk, i_rst_n, o_ctrl.exec, o_done)
    `ASSERT_NEXT(a_done_then_idle, i_clk, i_rst_n, o_done, !busy && !o_done)

endmodule

@@ rtl/bdeq_datapath.sv @@
`include "assert_macros.svh"

module bdeq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdeq_pkg::t_dp_ctrl i_ctrl,
    input  bdeq_pkg::t_req     i_req,
    output bdeq_pkg::t_rsp     o_rsp
);
    import bdeq_pkg::*;

    // Slot memory; it is read on every execute, but only slots that a push wrote reach the result.
    logic signed [31:0] mem [DEPTH];

    // Latched request.
    logic [2:0]         r_cmd;
    logic signed [31:0] r_data;

    // Queue state and result registers.
    logic [IDX_W-1:0]   r_front;
    logic [IDX_W-1:0]   n_front;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_status            r_status;
    t_status            n_status;
    logic               r_rd_ok;
    logic               n_rd_ok;
    logic signed [31:0] r_rd_data;

    logic               full;
    logic               empty;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [IDX_W-1:0]   tail_slot;
    logic [IDX_W-1:0]   back_slot;
    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   back_sum;

    // Ring arithmetic with wrap at the depth.
    always_comb begin
        full      = (r_count == CNT_W'(DEPTH));
        empty     = (r_count == '0);
        front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
        front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        tail_sum  = SUM_W'(r_front) + SUM_W'(r_count);
        back_sum  = tail_sum - 1'b1;
        tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
        back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);
    end

    // Command decode for the execute cycle.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = STAT_OK;
        n_rd_ok  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = tail_slot;
        rd_addr  = r_front;
        case (r_cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    rd_addr = back_slot;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_PEEK_FRONT: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            CMD_PEEK_BACK: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    rd_addr = back_slot;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_req.cmd;
            r_data <= i_req.data_in;
        end
    end

    // Queue pointers and result status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_status <= STAT_OK;
            r_rd_ok  <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Slot memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && wr_en) begin
            mem[wr_addr] <= r_data;
        end
        if (i_ctrl.exec) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Result fields.
    always_comb begin
        o_rsp.status     = r_status;
        o_rsp.data_out   = r_rd_ok ? r_rd_data : '0;
        o_rsp.item_count = 5'(r_count);
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `ASSERT_ALWAYS(a_front_bound, i_clk, i_rst_n, r_front <= IDX_W'(DEPTH - 1))
    `ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_ctrl.exec, $stable(r_count) && $stable(r_front))

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
// A request accepted at a clock edge passes through the execute state and yields its result in the response state.
// The block takes no new request until the last result is presented; the controller takes the
// request in idle, executes it with a registered slot read, and then presents the result.
// The receiver cannot stall: the result stands for exactly one cycle with o_done high.
// Synchronous active-low reset empties the queue and returns the controller to idle.
module bounded_double_ended_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bdeq_pkg::t_req   i_req,
    output logic             o_done,
    output bdeq_pkg::t_rsp   o_rsp
);
    import bdeq_pkg::*;

    t_dp_ctrl dp_ctrl;

    // Sequencing of each request.
    bdeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctrl  (dp_ctrl)
    );

    // Ring store, pointers and result registers.
    bdeq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dp_ctrl),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

@@ dv/tb.sv @@
module tb;
    import bdeq_pkg::*;

    // Command codes that the block treats as no-ops.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int DRAIN_LIMIT     = 200;

    // Traffic profiles for the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_rsp;

    // Predicted deque contents and the results still owed by the block.
    logic [31:0]      ring_words [DEPTH];
    logic [IDX_W-1:0] ring_front = '0;
    logic [CNT_W-1:0] ring_count = '0;
    t_rsp             owed_results [$];

    int mismatches    = 0;
    int requests_sent = 0;

    bounded_double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Apply one command to the predicted deque and return the result it owes.
    function automatic t_rsp apply_deque_cmd(input logic [2:0] cmd, input logic [31:0] word);
        t_rsp rsp;
        int   slot;
        rsp.status   = STAT_OK;
        rsp.data_out = '0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (ring_count == CNT_W'(DEPTH)) begin
                    rsp.status = STAT_FULL;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    ring_front = IDX_W'((int'(ring_front) + DEPTH - 1) % DEPTH);
                    ring_words[ring_front] = word;
                    ring_count = ring_count + 1'b1;
                end else begin
                    slot = (int'(ring_front) + int'(ring_count)) % DEPTH;
                    ring_words[slot] = word;
                    ring_count = ring_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (ring_count == '0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
                        slot = int'(ring_front);
                    end else begin
                        slot = (int'(ring_front) + int'(ring_count) - 1) % DEPTH;
                    end
                    rsp.data_out = ring_words[slot];
                    if (cmd == CMD_POP_FRONT) begin
                        ring_front = IDX_W'((int'(ring_front) + 1) % DEPTH);
                        ring_count = ring_count - 1'b1;
                    end else if (cmd == CMD_POP_BACK) begin
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.item_count = ring_count;
        return rsp;
    endfunction

    // Mostly no pause between requests, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Random word, with the extreme values mixed in now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Issue one request, record its predicted result once accepted, then maybe pause.
    task automatic send_request(input logic [2:0] cmd, input logic [31:0] word,
                                input bit allow_idle);
        t_req req;
        int   gap;
        req.cmd     = cmd;
        req.data_in = word;
        start <= 1'b1;
        i_req <= req;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        owed_results.push_back(apply_deque_cmd(cmd, word));
        requests_sent++;
        gap = allow_idle ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pops, peeks and spare codes on the empty queue after reset.
    task automatic test_empty_queue();
        send_request(CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_POP_BACK, 32'h0000_0000, 1'b1);
        send_request(CMD_PEEK_FRONT, 32'h8000_0000, 1'b1);
        send_request(CMD_PEEK_BACK, 32'h7FFF_FFFF, 1'b1);
        send_request(CMD_SPARE_A, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_SPARE_B, 32'h5A5A_A5A5, 1'b1);
    endtask

    // Fill from both ends, wrapping the front index, then push into the full queue.
    task automatic test_fill_to_full();
        logic [31:0] edge_words [4];
        edge_words[0] = 32'h8000_0000;
        edge_words[1] = 32'h7FFF_FFFF;
        edge_words[2] = 32'hFFFF_FFFF;
        edge_words[3] = 32'h0000_0000;
        for (int i = 0; i < DEPTH; i++) begin
            send_request((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                         (i < 4) ? edge_words[i] : pick_word(), i > 8);
        end
        send_request(CMD_PUSH_FRONT, 32'h1234_5678, 1'b1);
        send_request(CMD_PUSH_BACK, 32'hEDCB_A987, 1'b1);
    endtask

    // Random phases that drift the queue toward full, toward empty, or hold it level.
    task automatic test_random_traffic();
        t_mix        mix;
        int          phase_len;
        bit          allow_idle;
        int          roll;
        int          push_pct;
        int          pop_pct;
        logic [2:0]  cmd;
        bit          at_front;
        while (requests_sent < RANDOM_REQUESTS) begin
            mix        = t_mix'($urandom_range(0, 2));
            phase_len  = $urandom_range(10, 60);
            allow_idle = ($urandom_range(0, 3) != 0);
            case (mix)
                MIX_FILL:  begin push_pct = 70; pop_pct = 20; end
                MIX_DRAIN: begin push_pct = 20; pop_pct = 70; end
                default:   begin push_pct = 40; pop_pct = 40; end
            endcase
            repeat (phase_len) begin
                roll     = $urandom_range(0, 99);
                at_front = 1'($urandom_range(0, 1));
                if (roll < 3) begin
                    cmd = at_front ? CMD_SPARE_A : CMD_SPARE_B;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_pct) begin
                        cmd = at_front ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                    end else if (roll < push_pct + pop_pct) begin
                        cmd = at_front ? CMD_POP_FRONT : CMD_POP_BACK;
                    end else begin
                        cmd = at_front ? CMD_PEEK_FRONT : CMD_PEEK_BACK;
                    end
                end
                send_request(cmd, pick_word(), allow_idle);
            end
        end
    endtask

    // Report one field that differs from its prediction.
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Each result is matched against the oldest result still owed.
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result expected none, got %0h", $time, o_rsp);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_rsp.status));
                check_field("data_out", want.data_out, o_rsp.data_out);
                check_field("item_count", 32'(want.item_count), 32'(o_rsp.item_count));
            end
        end
    end

    // Reset, run the tests, then let the last results drain.
    initial begin
        int waited;
        waited = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_fill_to_full();
        test_random_traffic();
        start <= 1'b0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("bounded_double_ended_queue: match");
        end else begin
            $display("bounded_double_ended_queue: mismatch");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("bounded_double_ended_queue: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bdeq_pkg.sv
rtl/bdeq_ctrl.sv
rtl/bdeq_datapath.sv
rtl/bounded_double_ended_queue.sv
dv/tb.sv
